@@ rtl/vsa_pkg.sv @@
// Shared types, codes and widths for the voice slot allocator.
// No dependencies.
package vsa_pkg;

    localparam int VOICES_DEF = 32;

    localparam int MODE_W     = 2;
    localparam int SND_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int CAP_W      = 6;
    localparam int REL_W      = 5;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 5;
    localparam int COUNT_W    = 6;
    localparam int STEAL_W    = 32;
    localparam int AGE_W      = 40;

    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [GAIN_W-1:0] THRESH_RESET = 16'd1;
    localparam logic              REG_THRESHOLD = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_PLAY     = 2'd0,
        MODE_RELEASE  = 2'd1,
        MODE_STOP_ALL = 2'd2
    } vsa_mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FREE        = 3'd0,
        ST_STOLE_OWN   = 3'd1,
        ST_STOLE_QUIET = 3'd2,
        ST_TOO_QUIET   = 3'd3,
        ST_REFUSED     = 3'd4,
        ST_DONE        = 3'd5
    } vsa_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } vsa_state_t;

    typedef struct packed {
        logic accept;
        logic scan_issue;
        logic commit;
    } vsa_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } vsa_stat_t;

endpackage

@@ rtl/voice_slot_allocator_unit.sv @@
// Top level of the voice slot allocator: APB registers, controller and datapath.
// Depends on vsa_pkg, vsa_cfg, vsa_ctrl and vsa_dp.
//
// One word is taken at a time. A play request at or above the audible threshold
// scans the whole slot table through its single memory read port, one slot per
// cycle, before its result is committed; a quiet play request, a release or a
// stop-all goes from acceptance straight to commit. The next word is accepted
// from the cycle after the result is committed. The result sits in an output
// register, so the next word is accepted while it waits; a result still untaken
// holds back the commit of the following word.
// Active bits are flip-flops cleared by reset, so no clearing pass follows reset.
module voice_slot_allocator_unit #(
    parameter int VOICES = vsa_pkg::VOICES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vsa_pkg::APB_AW-1:0]     paddr,
    input  logic [vsa_pkg::APB_DW-1:0]     pwdata,
    output logic [vsa_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [vsa_pkg::MODE_W-1:0]     mode,
    input  logic [vsa_pkg::SND_W-1:0]      sound_id,
    input  logic [vsa_pkg::GAIN_W-1:0]     gain,
    input  logic [vsa_pkg::CAP_W-1:0]      instance_cap,
    input  logic [vsa_pkg::REL_W-1:0]      release_slot,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [vsa_pkg::STATUS_W-1:0]   status,
    output logic [vsa_pkg::SLOT_OUT_W-1:0] slot,
    output logic [vsa_pkg::COUNT_W-1:0]    active_count,
    output logic [vsa_pkg::STEAL_W-1:0]    steal_total
);
    import vsa_pkg::*;

    logic [GAIN_W-1:0] threshold;
    vsa_cmd_t          cmd;
    vsa_stat_t         stat;

    vsa_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .threshold (threshold)
    );

    vsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vsa_dp #(
        .VOICES (VOICES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .threshold    (threshold),
        .mode         (mode),
        .sound_id     (sound_id),
        .gain         (gain),
        .instance_cap (instance_cap),
        .release_slot (release_slot),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .status       (status),
        .slot         (slot),
        .active_count (active_count),
        .steal_total  (steal_total)
    );

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word accepted while one is in flight");

    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> stat.out_free)
        else $error("result committed over an untaken result");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid && in_ready)
        else $error("commit did not present a result and return to idle");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.commit))
        else $error("result appeared without a commit");

endmodule

@@ rtl/vsa_cfg.sv @@
// APB register block: holds the audible threshold.
// Depends on vsa_pkg.
module vsa_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [vsa_pkg::APB_AW-1:0] paddr,
    input  logic [vsa_pkg::APB_DW-1:0] pwdata,
    output logic [vsa_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output logic [vsa_pkg::GAIN_W-1:0] threshold
);
    import vsa_pkg::*;

    logic [GAIN_W-1:0] threshold_reg;
    logic [GAIN_W-1:0] threshold_next;
    logic              hit;

    assign pready = 1'b1;
    assign hit    = (paddr[2] == REG_THRESHOLD);

    always_comb
    begin
        threshold_next = threshold_reg;
        if (psel && penable && pwrite && pready && hit)
        begin
            threshold_next = pwdata[GAIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    assign prdata    = hit ? APB_DW'(threshold_reg) : '0;
    assign threshold = threshold_reg;

endmodule

@@ rtl/vsa_dp.sv @@
// Datapath: slot table memory, active bits, scan accumulators, decision and result register.
// Depends on vsa_pkg.
module vsa_dp #(
    parameter int VOICES = vsa_pkg::VOICES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  vsa_pkg::vsa_cmd_t            cmd,
    output vsa_pkg::vsa_stat_t           stat,
    input  logic [vsa_pkg::GAIN_W-1:0]   threshold,
    input  logic [vsa_pkg::MODE_W-1:0]   mode,
    input  logic [vsa_pkg::SND_W-1:0]    sound_id,
    input  logic [vsa_pkg::GAIN_W-1:0]   gain,
    input  logic [vsa_pkg::CAP_W-1:0]    instance_cap,
    input  logic [vsa_pkg::REL_W-1:0]    release_slot,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [vsa_pkg::STATUS_W-1:0] status,
    output logic [vsa_pkg::SLOT_OUT_W-1:0] slot,
    output logic [vsa_pkg::COUNT_W-1:0]  active_count,
    output logic [vsa_pkg::STEAL_W-1:0]  steal_total
);
    import vsa_pkg::*;

    localparam int SLOT_W = $clog2(VOICES);
    localparam int CNT_W  = $clog2(VOICES + 1);
    localparam int MEM_W  = SND_W + GAIN_W + AGE_W;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int REL_CW = (CNT_W > REL_W) ? CNT_W : REL_W;

    // slot table
    logic [MEM_W-1:0]  slot_mem_reg [VOICES];
    logic [MEM_W-1:0]  rd_data_reg;
    logic [VOICES-1:0] active_reg, active_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [AGE_W-1:0]  next_age_reg, next_age_next;
    logic [STEAL_W-1:0] steals_reg, steals_next;

    // latched request
    logic [MODE_W-1:0] req_mode_reg;
    logic [SND_W-1:0]  req_snd_reg;
    logic [GAIN_W-1:0] req_gain_reg;
    logic [CAP_W-1:0]  req_cap_reg;
    logic [REL_W-1:0]  req_rel_reg;
    logic              req_quiet_reg;

    // scan
    logic [CNT_W-1:0]  rd_cnt_reg;
    logic              cmp_vld_reg;
    logic [SLOT_W-1:0] cmp_idx_reg;
    logic              issue;
    logic [SLOT_W-1:0] rd_addr;

    logic [CNT_W-1:0]  inst_reg, inst_next;
    logic              old_found_reg, old_found_next;
    logic [SLOT_W-1:0] old_idx_reg, old_idx_next;
    logic [AGE_W-1:0]  old_age_reg, old_age_next;
    logic              free_found_reg, free_found_next;
    logic [SLOT_W-1:0] free_idx_reg, free_idx_next;
    logic              q_found_reg, q_found_next;
    logic [SLOT_W-1:0] q_idx_reg, q_idx_next;
    logic [GAIN_W-1:0] q_prio_reg, q_prio_next;
    logic [AGE_W-1:0]  q_age_reg, q_age_next;

    logic              c_act;
    logic [SND_W-1:0]  c_snd;
    logic [GAIN_W-1:0] c_prio;
    logic [AGE_W-1:0]  c_age;

    // decision
    vsa_status_t       dec_status;
    logic [SLOT_W-1:0] pick;
    logic              grant;
    logic              rel_in_range;
    logic [SLOT_W-1:0] rel_idx;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [SLOT_OUT_W-1:0] slot_reg;
    logic [COUNT_W-1:0]    count_out_reg;
    logic [STEAL_W-1:0]    steal_out_reg;

    assign issue   = cmd.scan_issue && (rd_cnt_reg != CNT_W'(VOICES));
    assign rd_addr = rd_cnt_reg[SLOT_W-1:0];

    assign stat.need_scan = (mode == MODE_PLAY) && (gain >= threshold);
    assign stat.scan_done = (rd_cnt_reg == CNT_W'(VOICES)) && !cmp_vld_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign c_act  = active_reg[cmp_idx_reg];
    assign c_snd  = rd_data_reg[MEM_W-1 -: SND_W];
    assign c_prio = rd_data_reg[AGE_W +: GAIN_W];
    assign c_age  = rd_data_reg[AGE_W-1:0];

    always_comb
    begin
        inst_next       = inst_reg;
        old_found_next  = old_found_reg;
        old_idx_next    = old_idx_reg;
        old_age_next    = old_age_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        q_found_next    = q_found_reg;
        q_idx_next      = q_idx_reg;
        q_prio_next     = q_prio_reg;
        q_age_next      = q_age_reg;
        if (cmd.accept)
        begin
            inst_next       = '0;
            old_found_next  = 1'b0;
            free_found_next = 1'b0;
            q_found_next    = 1'b0;
        end
        else if (cmp_vld_reg)
        begin
            if (c_act && (c_snd == req_snd_reg))
            begin
                inst_next = inst_reg + 1'b1;
                if (!old_found_reg || (c_age < old_age_reg))
                begin
                    old_found_next = 1'b1;
                    old_idx_next   = cmp_idx_reg;
                    old_age_next   = c_age;
                end
            end
            if (!c_act && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
            if ((c_prio <= req_gain_reg) &&
                (!q_found_reg || (c_prio < q_prio_reg) ||
                 ((c_prio == q_prio_reg) && (c_age < q_age_reg))))
            begin
                q_found_next = 1'b1;
                q_idx_next   = cmp_idx_reg;
                q_prio_next  = c_prio;
                q_age_next   = c_age;
            end
        end
    end

    assign rel_in_range = REL_CW'(req_rel_reg) < REL_CW'(VOICES);
    assign rel_idx      = SLOT_W'(req_rel_reg);

    always_comb
    begin
        dec_status = ST_DONE;
        pick       = '0;
        grant      = 1'b0;
        unique case (req_mode_reg)
            MODE_PLAY:
            begin
                if (req_quiet_reg)
                begin
                    dec_status = ST_TOO_QUIET;
                end
                else if ((req_cap_reg != '0) && old_found_reg &&
                         (CMP_W'(inst_reg) >= CMP_W'(req_cap_reg)))
                begin
                    dec_status = ST_STOLE_OWN;
                    pick       = old_idx_reg;
                    grant      = 1'b1;
                end
                else if (free_found_reg)
                begin
                    dec_status = ST_FREE;
                    pick       = free_idx_reg;
                    grant      = 1'b1;
                end
                else if (q_found_reg)
                begin
                    dec_status = ST_STOLE_QUIET;
                    pick       = q_idx_reg;
                    grant      = 1'b1;
                end
                else
                begin
                    dec_status = ST_REFUSED;
                end
            end
            default:
            begin
                dec_status = ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        active_next   = active_reg;
        count_next    = count_reg;
        next_age_next = next_age_reg;
        steals_next   = steals_reg;
        if (cmd.commit)
        begin
            unique case (req_mode_reg)
                MODE_PLAY:
                begin
                    if (grant)
                    begin
                        active_next[pick] = 1'b1;
                        next_age_next     = next_age_reg + 1'b1;
                        if (dec_status == ST_FREE)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            steals_next = steals_reg + 1'b1;
                        end
                    end
                end
                MODE_RELEASE:
                begin
                    if (rel_in_range && active_reg[rel_idx])
                    begin
                        active_next[rel_idx] = 1'b0;
                        count_next           = count_reg - 1'b1;
                    end
                end
                MODE_STOP_ALL:
                begin
                    active_next = '0;
                    count_next  = '0;
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            count_reg     <= '0;
            next_age_reg  <= '0;
            steals_reg    <= '0;
            rd_cnt_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            count_reg     <= count_next;
            next_age_reg  <= next_age_next;
            steals_reg    <= steals_next;
            cmp_vld_reg   <= issue;
            out_valid_reg <= out_valid_next;
            if (cmd.accept)
            begin
                rd_cnt_reg <= '0;
            end
            else if (issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= slot_mem_reg[rd_addr];
        end
        if (cmd.commit && grant)
        begin
            slot_mem_reg[pick] <= {req_snd_reg, req_gain_reg, next_age_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= rd_addr;
        inst_reg       <= inst_next;
        old_found_reg  <= old_found_next;
        old_idx_reg    <= old_idx_next;
        old_age_reg    <= old_age_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        q_found_reg    <= q_found_next;
        q_idx_reg      <= q_idx_next;
        q_prio_reg     <= q_prio_next;
        q_age_reg      <= q_age_next;
        if (cmd.accept)
        begin
            req_mode_reg  <= mode;
            req_snd_reg   <= sound_id;
            req_gain_reg  <= gain;
            req_cap_reg   <= instance_cap;
            req_rel_reg   <= release_slot;
            req_quiet_reg <= (gain < threshold);
        end
        if (cmd.commit)
        begin
            status_reg    <= dec_status;
            slot_reg      <= SLOT_OUT_W'(pick);
            count_out_reg <= COUNT_W'(count_next);
            steal_out_reg <= steals_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign slot         = slot_reg;
    assign active_count = count_out_reg;
    assign steal_total  = steal_out_reg;

endmodule

@@ rtl/vsa_ctrl.sv @@
// Controller: sequences accept, table scan and commit of one word at a time.
// Depends on vsa_pkg.
module vsa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vsa_pkg::vsa_stat_t stat,
    output vsa_pkg::vsa_cmd_t  cmd
);
    import vsa_pkg::*;

    vsa_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.need_scan ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
